>>> rtl/sga_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sga_pkg
// Shared widths, register codes, constants and types of the spatiogram block.
// ----------------------------------------------------------------------------
package sga_pkg;

	localparam int SAMPLE_W    = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int BINS_LOG2_W = 3;
	localparam int SIDE_W      = 9;
	localparam int CTR_W       = 8;
	localparam int HALF_W      = 8;
	localparam int K_W         = 18;
	localparam int ROOT_W      = 18;
	localparam int KSUM_W      = 34;
	localparam int CNT_W       = 17;
	localparam int SUM_W       = 25;
	localparam int SQ_W        = 33;
	localparam int COORD_W     = 9;
	localparam int COORD_SQ_W  = 17;
	localparam int BIN_NUM_W   = 6;
	localparam int WEIGHT_W    = 24;
	localparam int MEAN_W      = 17;
	localparam int VAR_W       = 23;

	localparam int MAX_SIDE     = 256;
	localparam int MIN_SIDE     = 2;
	localparam int DEF_MAX_BINS = 16;
	localparam int DEF_CHANNELS = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_BINS_LOG2    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PATCH_WIDTH  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PATCH_HEIGHT = 2'd3;

	localparam logic [BINS_LOG2_W-1:0] RST_BINS_LOG2    = 3'd3;
	localparam logic                   RST_COLOR_MODE   = 1'b1;
	localparam logic [SIDE_W-1:0]      RST_PATCH_WIDTH  = 9'd32;
	localparam logic [SIDE_W-1:0]      RST_PATCH_HEIGHT = 9'd32;

	// round(2/pi * 2^18)
	localparam logic [K_W-1:0]      KERNEL_COEF = 18'd166886;
	localparam logic [ROOT_W:0]     Q18_ONE     = 19'd262144;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = 24'hFFFFFF;
	localparam logic [MEAN_W-1:0]   MEAN_MAX    = 17'd65536;
	localparam logic [VAR_W-1:0]    VAR_MAX     = 23'd4194304;

	typedef struct packed {
		logic [KSUM_W-1:0] ksum;
		logic [CNT_W-1:0]  cnt;
		logic [SUM_W-1:0]  sx;
		logic [SUM_W-1:0]  sy;
		logic [SQ_W-1:0]   sxx;
		logic [SQ_W-1:0]   syy;
	} bin_acc_t;

	typedef struct packed {
		logic rd;
		logic acc;
		logic clr;
	} lane_ctl_t;

	typedef struct packed {
		logic [K_W-1:0]        k;
		logic [COORD_W-1:0]    x;
		logic [COORD_W-1:0]    y;
		logic [COORD_SQ_W-1:0] xsq;
		logic [COORD_SQ_W-1:0] ysq;
	} lane_incr_t;

	function automatic int floor_log2(input int v);
		int r;
		r = 0;
		for (int i = 0; i < 8; i++) begin
			if ((2 << i) <= v) r = i + 1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/sga_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sga_if
// Pixel and result channels of the spatiogram block.
// ----------------------------------------------------------------------------
interface sga_pix_if
	import sga_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_a;
	logic [SAMPLE_W-1:0] sample_b;
	logic [SAMPLE_W-1:0] sample_c;

	modport source (output valid, sample_a, sample_b, sample_c, input ready);
	modport sink (input valid, sample_a, sample_b, sample_c, output ready);
endinterface

interface sga_res_if
	import sga_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [BIN_NUM_W-1:0] bin_number;
	logic [WEIGHT_W-1:0]  weight;
	logic [MEAN_W-1:0]    mean_x;
	logic [MEAN_W-1:0]    mean_y;
	logic [VAR_W-1:0]     var_x;
	logic [VAR_W-1:0]     var_y;
	logic                 last_bin;

	modport source (output valid, bin_number, weight, mean_x, mean_y, var_x, var_y,
		last_bin, input ready);
	modport sink (input valid, bin_number, weight, mean_x, mean_y, var_x, var_y,
		last_bin, output ready);
endinterface
`default_nettype wire

>>> rtl/sga_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sga_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QW bits.
// ----------------------------------------------------------------------------
module sga_div
	import sga_pkg::*;
#(
	parameter int NW = 33,
	parameter int DW = 17,
	parameter int QW = 18
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic [QW-1:0]      quo
);
	localparam int CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] lo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic          ge;

	assign trial = {rem_q, lo_q[QW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	// The low part of the numerator shifts out at the top while quotient bits
	// shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(num >> QW);
			lo_q  <= num[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			lo_q  <= {lo_q[QW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = lo_q;
endmodule
`default_nettype wire

>>> rtl/sga_kernel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sga_kernel
// Cone kernel of one pixel, 2/pi * (1 - r): squared distances, a ratio divide, an
// integer square root and the final scaling multiply.
// ----------------------------------------------------------------------------
module sga_kernel
	import sga_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CTR_W-1:0]  col,
	input  wire logic [CTR_W-1:0]  row,
	input  wire logic [HALF_W-1:0] hw,
	input  wire logic [HALF_W-1:0] hh,
	output logic                   busy,
	output logic [K_W-1:0]         k
);
	localparam int D_W   = 10;
	localparam int D2_W  = 17;
	localparam int M2_W  = 16;
	localparam int QR_W  = 36;
	localparam int NUM_W = M2_W + QR_W;
	localparam int REM_W = ROOT_W + 4;

	typedef enum logic [2:0] {K_IDLE, K_SQ, K_CMP, K_DIV, K_SQRT, K_MUL} kstate_t;

	kstate_t                   state_q;
	logic signed [D_W-1:0]     dx_q, dy_q;
	logic [HALF_W-1:0]         hw_q, hh_q;
	logic [D2_W-1:0]           d2_q;
	logic [M2_W-1:0]           m2_q;
	logic [QR_W-1:0]           sq_q;
	logic [ROOT_W-1:0]         root_q;
	logic [REM_W-1:0]          rem_q;
	logic [4:0]                it_q;
	logic [K_W-1:0]            k_q;
	logic                      div_start;
	logic                      div_busy;
	logic [QR_W-1:0]           div_quo;
	logic [NUM_W-1:0]          div_num;
	logic [REM_W-1:0]          rem_n;
	logic [REM_W-1:0]          trial;
	logic signed [2*D_W-1:0]   dx2, dy2;
	logic [2*K_W:0]            prod;

	assign dx2   = dx_q * dx_q;
	assign dy2   = dy_q * dy_q;
	assign rem_n = {rem_q[REM_W-3:0], sq_q[QR_W-1:QR_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign prod  = (2*K_W+1)'(KERNEL_COEF) * (2*K_W+1)'(Q18_ONE - {1'b0, root_q});

	// The ratio is only formed when d2 < m2, so d2 fits in the width of m2.
	assign div_start = (state_q == K_CMP) && (d2_q < {1'b0, m2_q});
	assign div_num   = {d2_q[M2_W-1:0], {QR_W{1'b0}}};

	sga_div #(.NW(NUM_W), .DW(M2_W), .QW(QR_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (m2_q),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= K_IDLE;
			it_q    <= '0;
		end else begin
			unique case (state_q)
				K_IDLE: if (start) state_q <= K_SQ;
				K_SQ:   state_q <= K_CMP;
				K_CMP:  state_q <= div_start ? K_DIV : K_IDLE;
				K_DIV: begin
					if (!div_busy) begin
						state_q <= K_SQRT;
						it_q    <= 5'(ROOT_W);
					end
				end
				K_SQRT: begin
					it_q <= it_q - 5'd1;
					if (it_q == 5'd1) state_q <= K_MUL;
				end
				K_MUL:  state_q <= K_IDLE;
				default: state_q <= K_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == K_IDLE && start) begin
			dx_q <= $signed({2'b00, col}) - $signed({2'b00, hw});
			dy_q <= $signed({2'b00, row}) - $signed({2'b00, hh});
			hw_q <= hw;
			hh_q <= hh;
		end
		if (state_q == K_SQ) begin
			d2_q <= D2_W'(dx2) + D2_W'(dy2);
			m2_q <= M2_W'({8'b0, hw_q} * {8'b0, hw_q}) + M2_W'({8'b0, hh_q} * {8'b0, hh_q});
		end
		// A pixel at or beyond the rim gets no weight.
		if (state_q == K_CMP && !div_start) k_q <= '0;
		if (state_q == K_DIV && !div_busy) begin
			sq_q   <= div_quo;
			root_q <= '0;
			rem_q  <= '0;
		end
		if (state_q == K_SQRT) begin
			sq_q <= {sq_q[QR_W-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (state_q == K_MUL) k_q <= prod[2*K_W-1:K_W];
	end

	assign busy = (state_q != K_IDLE);
	assign k    = k_q;
endmodule
`default_nettype wire

>>> rtl/sga_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sga_lane
// Bin store of one color channel with read-modify-write accumulation.
// ----------------------------------------------------------------------------
module sga_lane
	import sga_pkg::*;
#(
	parameter int MAX_BINS = DEF_MAX_BINS,
	localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lane_ctl_t        ctl,
	input  wire logic [BIN_W-1:0] addr,
	input  wire lane_incr_t       incr,
	output bin_acc_t              data
);
	bin_acc_t              mem [MAX_BINS];
	logic [MAX_BINS-1:0]   vld_q;
	bin_acc_t              rd_q;
	logic                  rd_vld_q;
	bin_acc_t              cur;
	bin_acc_t              upd;

	// An entry that was not written since the last clear reads as zero.
	assign cur = rd_vld_q ? rd_q : '0;

	always_comb begin
		upd.ksum = cur.ksum + KSUM_W'(incr.k);
		upd.cnt  = cur.cnt + CNT_W'(1);
		upd.sx   = cur.sx + SUM_W'(incr.x);
		upd.sy   = cur.sy + SUM_W'(incr.y);
		upd.sxx  = cur.sxx + SQ_W'(incr.xsq);
		upd.syy  = cur.syy + SQ_W'(incr.ysq);
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) rd_q <= mem[addr];
		if (ctl.acc) mem[addr] <= upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else if (ctl.clr) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.acc) vld_q[addr] <= 1'b1;
			if (ctl.rd) rd_vld_q <= vld_q[addr];
		end
	end

	assign data = cur;
endmodule
`default_nettype wire

>>> rtl/spatiogram_accumulate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spatiogram_accumulate
// Second-order spatiogram of an image patch: per-bin kernel mass, position
// means and variances, read out after the last pixel.
// ----------------------------------------------------------------------------
//  port     dir   transfer         contents
//  pix      in    valid & ready    sample_a, sample_b, sample_c
//  res      out   valid & ready    bin_number, weight, means, variances, last
//  cfg      in    cfg_we           cfg_index, cfg_data
//
//  A pixel passes through the ratio divide and the square root in the kernel
//  unit, then a read and a write of the lane stores. A pixel outside the
//  kernel rim skips both. Each bin of the readout is paced by the 25-bit
//  weight divide and by any wait of res on ready. pix is not ready while a
//  pixel or a readout is in progress. Reset clears all counters and valid
//  bits at once, so every sum reads as zero.
// ----------------------------------------------------------------------------
module spatiogram_accumulate
	import sga_pkg::*;
#(
	parameter int MAX_BINS = DEF_MAX_BINS,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	sga_pix_if.sink                     pix,
	sga_res_if.source                   res
);
	localparam int BIN_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int LANE_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int LOG2_MAX = floor_log2(MAX_BINS);
	localparam int DEN_W    = 35;
	localparam int PROD_W   = 50;
	localparam int DSQ_W    = 33;
	localparam int WQ_W     = 25;
	localparam int MQ_W     = 18;
	localparam int VQ_W     = 23;
	localparam int WN_W     = 59;
	localparam int MN_W     = 33;
	localparam int VN_W     = 59;

	typedef enum logic [3:0] {
		S_IDLE, S_KERN, S_RD, S_ACC, S_O_RD, S_O_LOAD, S_O_MUL, S_O_SUB, S_O_DIV, S_O_SEND
	} state_t;

	state_t                  state_q;
	logic [BINS_LOG2_W-1:0]  bins_log2_q;
	logic                    color_mode_q;
	logic [SIDE_W-1:0]       patch_width_q;
	logic [SIDE_W-1:0]       patch_height_q;
	logic [CTR_W-1:0]        col_q, row_q;
	logic                    patch_end_q;
	logic [KSUM_W-1:0]       total_q;
	logic [LANE_W-1:0]       lane_q;
	logic [BIN_W-1:0]        bin_q;

	logic [BINS_LOG2_W-1:0]  lb;
	logic [1:0]              nch;
	logic [SIDE_W-1:0]       w, h;
	logic                    pix_xfer, res_xfer;
	logic                    row_end, patch_end;
	logic [BIN_W-1:0]        last_bin_idx;
	logic                    last_slot;
	logic [SAMPLE_W-1:0]     samp [3];
	logic [COORD_W-1:0]      x_now, y_now;

	logic [BIN_W-1:0]        bin_s1 [CHANNELS];
	lane_incr_t              incr_s1;
	lane_incr_t              incr;
	logic                    kern_busy;
	logic [K_W-1:0]          k;

	bin_acc_t                lane_data [CHANNELS];
	bin_acc_t                ent_s2;
	logic [DEN_W-1:0]        den_s2;
	logic [PROD_W-1:0]       ax_s3, bx_s3, ay_s3, by_s3;
	logic [DSQ_W-1:0]        dd_s3;
	logic [PROD_W-1:0]       diff_x, diff_y;

	logic                    div_start;
	logic [4:0]              div_busy;
	logic [WQ_W-1:0]         wq;
	logic [MQ_W-1:0]         mxq, myq;
	logic [VQ_W-1:0]         vxq, vyq;
	logic [WN_W-1:0]         w_num;
	logic [MN_W-1:0]         mx_num, my_num;
	logic [VN_W-1:0]         vx_num, vy_num;

	logic [BIN_NUM_W-1:0]    res_bin_q;
	logic [WEIGHT_W-1:0]     res_weight_q;
	logic [MEAN_W-1:0]       res_mean_x_q, res_mean_y_q;
	logic [VAR_W-1:0]        res_var_x_q, res_var_y_q;
	logic                    res_last_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_log2_q    <= RST_BINS_LOG2;
			color_mode_q   <= RST_COLOR_MODE;
			patch_width_q  <= RST_PATCH_WIDTH;
			patch_height_q <= RST_PATCH_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BINS_LOG2:    bins_log2_q    <= cfg_data[BINS_LOG2_W-1:0];
				REG_COLOR_MODE:   color_mode_q   <= cfg_data[0];
				REG_PATCH_WIDTH:  patch_width_q  <= cfg_data;
				REG_PATCH_HEIGHT: patch_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lb  = (bins_log2_q > BINS_LOG2_W'(LOG2_MAX)) ? BINS_LOG2_W'(LOG2_MAX) : bins_log2_q;
	assign nch = color_mode_q ? 2'(CHANNELS) : 2'd1;
	assign w   = (patch_width_q < SIDE_W'(MIN_SIDE)) ? SIDE_W'(MIN_SIDE) :
		(patch_width_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : patch_width_q;
	assign h   = (patch_height_q < SIDE_W'(MIN_SIDE)) ? SIDE_W'(MIN_SIDE) :
		(patch_height_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : patch_height_q;

	assign pix_xfer  = pix.valid && pix.ready;
	assign res_xfer  = res.valid && res.ready;
	assign row_end   = ({1'b0, col_q} + SIDE_W'(1)) >= w;
	assign patch_end = row_end && (({1'b0, row_q} + SIDE_W'(1)) >= h);

	assign last_bin_idx = BIN_W'(((BIN_W+1)'(1) << lb) - (BIN_W+1)'(1));
	assign last_slot    = (bin_q == last_bin_idx) && (lane_q == LANE_W'(nch - 2'd1));

	assign samp[0] = pix.sample_a;
	assign samp[1] = pix.sample_b;
	assign samp[2] = pix.sample_c;
	assign x_now   = COORD_W'(col_q) + COORD_W'(1);
	assign y_now   = COORD_W'(row_q) + COORD_W'(1);

	sga_kernel u_kernel (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pix_xfer),
		.col    (col_q),
		.row    (row_q),
		.hw     (w[SIDE_W-1:1]),
		.hh     (h[SIDE_W-1:1]),
		.busy   (kern_busy),
		.k      (k)
	);

	always_comb begin
		incr     = incr_s1;
		incr.k   = k;
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		lane_ctl_t        ctl;
		logic [BIN_W-1:0] addr;

		assign ctl.rd  = (state_q == S_RD) || (state_q == S_O_RD);
		assign ctl.acc = (state_q == S_ACC) && (2'(c) < nch);
		assign ctl.clr = (state_q == S_O_SEND) && res_xfer && last_slot;
		assign addr    = (state_q == S_RD || state_q == S_ACC) ? bin_s1[c] : bin_q;

		always_ff @(posedge clk) begin
			if (pix_xfer) bin_s1[c] <= BIN_W'(samp[c] >> (4'd8 - 4'(lb)));
		end

		sga_lane #(.MAX_BINS(MAX_BINS)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.addr   (addr),
			.incr   (incr),
			.data   (lane_data[c])
		);
	end

	// Readout numerators, all rounded to nearest.
	assign diff_x = (ax_s3 > bx_s3) ? (ax_s3 - bx_s3) : '0;
	assign diff_y = (ay_s3 > by_s3) ? (ay_s3 - by_s3) : '0;
	assign w_num  = (WN_W'(ent_s2.ksum) << 24) + WN_W'(den_s2 >> 1);
	assign mx_num = (MN_W'(ent_s2.sx) << 8) + MN_W'(ent_s2.cnt >> 1);
	assign my_num = (MN_W'(ent_s2.sy) << 8) + MN_W'(ent_s2.cnt >> 1);
	assign vx_num = (VN_W'(diff_x) << 8) + VN_W'(dd_s3 >> 1);
	assign vy_num = (VN_W'(diff_y) << 8) + VN_W'(dd_s3 >> 1);
	assign div_start = (state_q == S_O_SUB);

	sga_div #(.NW(WN_W), .DW(DEN_W), .QW(WQ_W)) u_div_w (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(w_num), .den(den_s2),
		.busy(div_busy[0]), .quo(wq)
	);
	sga_div #(.NW(MN_W), .DW(CNT_W), .QW(MQ_W)) u_div_mx (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(mx_num), .den(ent_s2.cnt),
		.busy(div_busy[1]), .quo(mxq)
	);
	sga_div #(.NW(MN_W), .DW(CNT_W), .QW(MQ_W)) u_div_my (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(my_num), .den(ent_s2.cnt),
		.busy(div_busy[2]), .quo(myq)
	);
	sga_div #(.NW(VN_W), .DW(DSQ_W), .QW(VQ_W)) u_div_vx (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(vx_num), .den(dd_s3),
		.busy(div_busy[3]), .quo(vxq)
	);
	sga_div #(.NW(VN_W), .DW(DSQ_W), .QW(VQ_W)) u_div_vy (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(vy_num), .den(dd_s3),
		.busy(div_busy[4]), .quo(vyq)
	);

	// Sequencer: one pixel or one readout bin at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			patch_end_q <= 1'b0;
			total_q     <= '0;
			lane_q      <= '0;
			bin_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pix_xfer) begin
						state_q     <= S_KERN;
						patch_end_q <= patch_end;
						if (row_end) begin
							col_q <= '0;
							row_q <= row_q + CTR_W'(1);
						end else begin
							col_q <= col_q + CTR_W'(1);
						end
					end
				end
				S_KERN: if (!kern_busy) state_q <= S_RD;
				S_RD:   state_q <= S_ACC;
				S_ACC: begin
					total_q <= total_q + KSUM_W'(k);
					if (patch_end_q) begin
						state_q <= S_O_RD;
						lane_q  <= '0;
						bin_q   <= '0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_O_RD:   state_q <= S_O_LOAD;
				S_O_LOAD: state_q <= S_O_MUL;
				S_O_MUL:  state_q <= S_O_SUB;
				S_O_SUB:  state_q <= S_O_DIV;
				S_O_DIV:  if (div_busy == '0) state_q <= S_O_SEND;
				S_O_SEND: begin
					if (res_xfer) begin
						if (last_slot) begin
							state_q <= S_IDLE;
							total_q <= '0;
							col_q   <= '0;
							row_q   <= '0;
						end else begin
							state_q <= S_O_RD;
							if (bin_q == last_bin_idx) begin
								bin_q  <= '0;
								lane_q <= lane_q + LANE_W'(1);
							end else begin
								bin_q <= bin_q + BIN_W'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pix_xfer) begin
			incr_s1.k   <= '0;
			incr_s1.x   <= x_now;
			incr_s1.y   <= y_now;
			incr_s1.xsq <= COORD_SQ_W'({8'b0, x_now} * {8'b0, x_now});
			incr_s1.ysq <= COORD_SQ_W'({8'b0, y_now} * {8'b0, y_now});
		end
		if (state_q == S_O_LOAD) begin
			ent_s2 <= lane_data[lane_q];
			den_s2 <= DEN_W'(total_q) * DEN_W'(nch);
		end
		if (state_q == S_O_MUL) begin
			ax_s3 <= PROD_W'(ent_s2.cnt) * PROD_W'(ent_s2.sxx);
			ay_s3 <= PROD_W'(ent_s2.cnt) * PROD_W'(ent_s2.syy);
			bx_s3 <= PROD_W'(ent_s2.sx) * PROD_W'(ent_s2.sx);
			by_s3 <= PROD_W'(ent_s2.sy) * PROD_W'(ent_s2.sy);
			dd_s3 <= DSQ_W'(ent_s2.cnt) * DSQ_W'(ent_s2.cnt);
		end
		if (state_q == S_O_DIV && div_busy == '0) begin
			res_bin_q  <= (BIN_NUM_W'(lane_q) << lb) | BIN_NUM_W'(bin_q);
			res_last_q <= last_slot;
			// An empty bin still carries one LSB of weight.
			if (ent_s2.ksum == '0 || den_s2 == '0) res_weight_q <= WEIGHT_W'(1);
			else if (wq > WQ_W'(WEIGHT_MAX)) res_weight_q <= WEIGHT_MAX;
			else res_weight_q <= wq[WEIGHT_W-1:0];
			if (ent_s2.cnt == '0) begin
				res_mean_x_q <= '0;
				res_mean_y_q <= '0;
				res_var_x_q  <= '0;
				res_var_y_q  <= '0;
			end else begin
				res_mean_x_q <= (mxq > MQ_W'(MEAN_MAX)) ? MEAN_MAX : mxq[MEAN_W-1:0];
				res_mean_y_q <= (myq > MQ_W'(MEAN_MAX)) ? MEAN_MAX : myq[MEAN_W-1:0];
				res_var_x_q  <= (vxq > VAR_MAX) ? VAR_MAX : vxq;
				res_var_y_q  <= (vyq > VAR_MAX) ? VAR_MAX : vyq;
			end
		end
	end

	assign pix.ready      = (state_q == S_IDLE);
	assign res.valid      = (state_q == S_O_SEND);
	assign res.bin_number = res_bin_q;
	assign res.weight     = res_weight_q;
	assign res.mean_x     = res_mean_x_q;
	assign res.mean_y     = res_mean_y_q;
	assign res.var_x      = res_var_x_q;
	assign res.var_y      = res_var_y_q;
	assign res.last_bin   = res_last_q;

	// A pixel is never taken while results are pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(pix.ready && res.valid))
		else $error("pixel channel ready during readout");

	// Every accepted pixel starts the kernel unit.
	a_kern_start: assert property (@(posedge clk) disable iff (!arst_n)
		pix_xfer |=> kern_busy)
		else $error("kernel unit did not start");

	// After the final bin of a patch the block takes pixels again.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && res.last_bin |=> pix.ready)
		else $error("block not idle after last bin");

	// Bin numbers stay within the configured channels and bins.
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ({1'b0, res.bin_number} < ((BIN_NUM_W+1)'(nch) << lb)))
		else $error("bin number out of range");
endmodule
`default_nettype wire
